// ===== rtl/vrp_pkg.sv =====
// Shared types and constants for the vertex rotate and project block.
// Used by vrp_divpipe and vertex_rotate_project; depends on nothing.

package vrp_pkg;

  localparam int CRD_W  = 32;
  localparam int TRG_W  = 16;
  localparam int SD_W   = 31;
  localparam int CTR_W  = 12;
  localparam int PIX_W  = 16;
  localparam int NUM_W  = CRD_W + SD_W;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [2:0] REG_YAW   = 3'd0;
  localparam logic [2:0] REG_PITCH = 3'd1;
  localparam logic [2:0] REG_CAMX  = 3'd2;
  localparam logic [2:0] REG_CAMY  = 3'd3;
  localparam logic [2:0] REG_CAMZ  = 3'd4;
  localparam logic [2:0] REG_SDIST = 3'd5;
  localparam logic [2:0] REG_HALFW = 3'd6;
  localparam logic [2:0] REG_HALFH = 3'd7;

  localparam logic [31:0]      YAW_RST   = 32'd16384;
  localparam logic [31:0]      PITCH_RST = 32'd16384;
  localparam logic [SD_W-1:0]  SDIST_RST = 31'd65536;
  localparam logic [CTR_W-1:0] HALFW_RST = 12'd320;
  localparam logic [CTR_W-1:0] HALFH_RST = 12'd240;

  typedef struct packed {
    logic clip;
    logic zbad;
    logic x_neg;
    logic y_neg;
  } vrp_side_t;

endpackage

// ===== rtl/vertex_rotate_project.sv =====
// Top level: rotates a vertex by yaw and pitch, adds the camera offset and projects it.
// Depends on vrp_pkg and vrp_divpipe.
//
// A request is taken on start whenever busy is low; busy is always low, so one
// vertex (in_vx, in_vy, in_vz) can be issued in every cycle.
// Each request yields exactly one screen point on out_px, out_py and out_clipped,
// marked by out_valid for a single cycle, in request order.
// Most of the pipeline depth comes from the divider, which resolves one quotient
// bit per stage over COORD_FRAC_BITS + 18 stages; throughput is one point per cycle.
// The receiver cannot stall, so the pipeline never holds.
// The registers sit on an APB-style port at byte address 4*index; the user must write
// them only while no request is in flight, as the block itself does not enforce it.
// Synchronous reset clears the pipeline valid bits and restores the register
// defaults; results in flight are dropped.

module vertex_rotate_project #(
  parameter int COORD_FRAC_BITS = 16,
  parameter int TRIG_FRAC_BITS  = 14
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [vrp_pkg::CRD_W-1:0]   in_vx,
  input  logic signed [vrp_pkg::CRD_W-1:0]   in_vy,
  input  logic signed [vrp_pkg::CRD_W-1:0]   in_vz,
  output logic                               out_valid,
  output logic signed [vrp_pkg::PIX_W-1:0]   out_px,
  output logic signed [vrp_pkg::PIX_W-1:0]   out_py,
  output logic                               out_clipped,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [vrp_pkg::ADDR_W-1:0]         paddr,
  input  logic [vrp_pkg::DATA_W-1:0]         pwdata,
  output logic [vrp_pkg::DATA_W-1:0]         prdata,
  output logic                               pready
);

  localparam int CW = vrp_pkg::CRD_W;
  localparam int TW16 = vrp_pkg::TRG_W;
  localparam int PW = CW + TW16;
  localparam int SW = PW + 2;
  localparam int NW = vrp_pkg::NUM_W;
  localparam int DW = vrp_pkg::SD_W;
  localparam int QB = COORD_FRAC_BITS + 18;
  localparam int TW = QB + 2;
  localparam int XW = vrp_pkg::PIX_W;
  localparam logic signed [SW-1:0] RND = SW'(1) <<< (TRIG_FRAC_BITS - 1);
  localparam logic [TW-1:0] FMASK = (TW'(1) << COORD_FRAC_BITS) - TW'(1);
  localparam logic signed [CW-1:0] I32_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] I32_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [XW-1:0] PIX_MAX = {1'b0, {(XW-1){1'b1}}};
  localparam logic signed [XW-1:0] PIX_MIN = {1'b1, {(XW-1){1'b0}}};

  logic [31:0]               yaw_r, pitch_r;
  logic signed [CW-1:0]      camx_r, camy_r, camz_r;
  logic [DW-1:0]             sd_r;
  logic [vrp_pkg::CTR_W-1:0] hw_r, hh_r;
  logic                      wr_en;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      yaw_r   <= vrp_pkg::YAW_RST;
      pitch_r <= vrp_pkg::PITCH_RST;
      camx_r  <= '0;
      camy_r  <= '0;
      camz_r  <= '0;
      sd_r    <= vrp_pkg::SDIST_RST;
      hw_r    <= vrp_pkg::HALFW_RST;
      hh_r    <= vrp_pkg::HALFH_RST;
    end else if (wr_en) begin
      case (paddr[4:2])
        vrp_pkg::REG_YAW:   yaw_r   <= pwdata;
        vrp_pkg::REG_PITCH: pitch_r <= pwdata;
        vrp_pkg::REG_CAMX:  camx_r  <= pwdata;
        vrp_pkg::REG_CAMY:  camy_r  <= pwdata;
        vrp_pkg::REG_CAMZ:  camz_r  <= pwdata;
        vrp_pkg::REG_SDIST: sd_r    <= pwdata[DW-1:0];
        vrp_pkg::REG_HALFW: hw_r    <= pwdata[vrp_pkg::CTR_W-1:0];
        vrp_pkg::REG_HALFH: hh_r    <= pwdata[vrp_pkg::CTR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      vrp_pkg::REG_YAW:   prdata = yaw_r;
      vrp_pkg::REG_PITCH: prdata = pitch_r;
      vrp_pkg::REG_CAMX:  prdata = camx_r;
      vrp_pkg::REG_CAMY:  prdata = camy_r;
      vrp_pkg::REG_CAMZ:  prdata = camz_r;
      vrp_pkg::REG_SDIST: prdata = 32'(sd_r);
      vrp_pkg::REG_HALFW: prdata = 32'(hw_r);
      vrp_pkg::REG_HALFH: prdata = 32'(hh_r);
      default:            prdata = '0;
    endcase
  end

  function automatic logic [CW:0] sat_rot(input logic signed [SW-1:0] v);
    logic fits;
    fits = (v[SW-1:CW-1] == {(SW-CW+1){v[CW-1]}});
    if (fits) begin
      sat_rot = {1'b0, v[CW-1:0]};
    end else begin
      sat_rot = {1'b1, v[SW-1] ? I32_MIN : I32_MAX};
    end
  endfunction

  function automatic logic [CW:0] sat_cam(input logic signed [CW:0] v);
    if (v[CW] == v[CW-1]) begin
      sat_cam = {1'b0, v[CW-1:0]};
    end else begin
      sat_cam = {1'b1, v[CW] ? I32_MIN : I32_MAX};
    end
  endfunction

  function automatic logic [XW:0] sat_pix(input logic signed [TW-1:0] v);
    if (v[TW-1:XW-1] == {(TW-XW+1){v[XW-1]}}) begin
      sat_pix = {1'b0, v[XW-1:0]};
    end else begin
      sat_pix = {1'b1, v[TW-1] ? PIX_MIN : PIX_MAX};
    end
  endfunction

  logic signed [TW16-1:0] yc, ys, pc, ps;
  assign yc = yaw_r[15:0];
  assign ys = yaw_r[31:16];
  assign pc = pitch_r[15:0];
  assign ps = pitch_r[31:16];

  // Input capture.
  logic                 v0_r;
  logic signed [CW-1:0] x0_r, y0_r, z0_r;

  // Yaw products.
  logic                 v1_r;
  logic signed [PW-1:0] mxc1_r, mzs1_r, mzc1_r, mxs1_r;
  logic signed [CW-1:0] y1_r;

  // Yaw sums.
  logic                 v2_r, c2_r;
  logic signed [CW-1:0] x2_r, y2_r, z2_r;
  logic signed [SW-1:0] sx1, sz1;
  logic [CW:0]          rx1, rz1;

  // Pitch products.
  logic                 v3_r, c3_r;
  logic signed [PW-1:0] myc3_r, mzs3_r, mzc3_r, mys3_r;
  logic signed [CW-1:0] x3_r;

  // Pitch sums.
  logic                 v4_r, c4_r;
  logic signed [CW-1:0] x4_r, y4_r, z4_r;
  logic signed [SW-1:0] sy2, sz2;
  logic [CW:0]          ry2, rz2;

  // Camera offset.
  logic                 v5_r, c5_r;
  logic signed [CW-1:0] x5_r, y5_r, z5_r;
  logic [CW:0]          cx5, cy5, cz5;

  // Magnitudes and depth check.
  logic                 v6_r;
  logic [CW-1:0]        xm6_r, ym6_r;
  logic [DW-1:0]        den6_r;
  vrp_pkg::vrp_side_t   side6_r;
  logic                 zbad5;

  // Dividends.
  logic                 v7_r;
  logic [NW-1:0]        nx7_r, ny7_r;
  logic [DW-1:0]        den7_r;
  vrp_pkg::vrp_side_t   side7_r;

  // Divider outputs.
  logic                 dv_valid;
  logic [QB-1:0]        dq_x, dq_y;
  logic                 dovf_x, dovf_y;
  vrp_pkg::vrp_side_t   dside;

  // Signed totals with the screen center.
  logic                 v8_r;
  logic signed [TW-1:0] tx8_r, ty8_r;
  vrp_pkg::vrp_side_t   side8_r;
  logic [QB-1:0]        qmx, qmy;
  logic signed [TW-1:0] qsx, qsy, cenx, ceny;

  // Truncation and pixel saturation.
  logic signed [TW-1:0] tx9, ty9, shx, shy;
  logic [XW:0]          pxs, pys;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v0_r <= start & ~busy;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
      v8_r <= dv_valid;
      out_valid <= v8_r;
    end
  end

  assign sx1 = SW'(mxc1_r) - SW'(mzs1_r) + RND;
  assign sz1 = SW'(mzc1_r) + SW'(mxs1_r) + RND;
  assign rx1 = sat_rot(sx1 >>> TRIG_FRAC_BITS);
  assign rz1 = sat_rot(sz1 >>> TRIG_FRAC_BITS);

  assign sy2 = SW'(myc3_r) - SW'(mzs3_r) + RND;
  assign sz2 = SW'(mzc3_r) + SW'(mys3_r) + RND;
  assign ry2 = sat_rot(sy2 >>> TRIG_FRAC_BITS);
  assign rz2 = sat_rot(sz2 >>> TRIG_FRAC_BITS);

  assign cx5 = sat_cam((CW+1)'(x4_r) + (CW+1)'(camx_r));
  assign cy5 = sat_cam((CW+1)'(y4_r) + (CW+1)'(camy_r));
  assign cz5 = sat_cam((CW+1)'(z4_r) + (CW+1)'(camz_r));

  assign zbad5 = z5_r[CW-1] | (z5_r == '0);

  always_ff @(posedge clk) begin
    x0_r <= in_vx;
    y0_r <= in_vy;
    z0_r <= in_vz;

    mxc1_r <= x0_r * yc;
    mzs1_r <= z0_r * ys;
    mzc1_r <= z0_r * yc;
    mxs1_r <= x0_r * ys;
    y1_r   <= y0_r;

    x2_r <= rx1[CW-1:0];
    z2_r <= rz1[CW-1:0];
    y2_r <= y1_r;
    c2_r <= rx1[CW] | rz1[CW];

    myc3_r <= y2_r * pc;
    mzs3_r <= z2_r * ps;
    mzc3_r <= z2_r * pc;
    mys3_r <= y2_r * ps;
    x3_r   <= x2_r;
    c3_r   <= c2_r;

    x4_r <= x3_r;
    y4_r <= ry2[CW-1:0];
    z4_r <= rz2[CW-1:0];
    c4_r <= c3_r | ry2[CW] | rz2[CW];

    x5_r <= cx5[CW-1:0];
    y5_r <= cy5[CW-1:0];
    z5_r <= cz5[CW-1:0];
    c5_r <= c4_r | cx5[CW] | cy5[CW] | cz5[CW];

    xm6_r <= x5_r[CW-1] ? CW'(-x5_r) : x5_r;
    ym6_r <= y5_r[CW-1] ? CW'(-y5_r) : y5_r;
    den6_r <= zbad5 ? DW'(1) : z5_r[DW-1:0];
    side6_r.clip  <= c5_r;
    side6_r.zbad  <= zbad5;
    side6_r.x_neg <= x5_r[CW-1];
    side6_r.y_neg <= y5_r[CW-1];

    nx7_r   <= NW'(xm6_r) * NW'(sd_r);
    ny7_r   <= NW'(ym6_r) * NW'(sd_r);
    den7_r  <= den6_r;
    side7_r <= side6_r;

    tx8_r   <= cenx + qsx;
    ty8_r   <= ceny + qsy;
    side8_r <= dside;

    out_px <= side8_r.zbad ? (side8_r.x_neg ? PIX_MIN : PIX_MAX) : pxs[XW-1:0];
    out_py <= side8_r.zbad ? (side8_r.y_neg ? PIX_MIN : PIX_MAX) : pys[XW-1:0];
    out_clipped <= side8_r.clip | side8_r.zbad | pxs[XW] | pys[XW];
  end

  vrp_divpipe #(
    .QBITS(QB)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (v7_r),
    .num_x    (nx7_r),
    .num_y    (ny7_r),
    .den      (den7_r),
    .side_in  (side7_r),
    .out_valid(dv_valid),
    .quo_x    (dq_x),
    .quo_y    (dq_y),
    .ovf_x    (dovf_x),
    .ovf_y    (dovf_y),
    .side_out (dside)
  );

  assign qmx  = dovf_x ? '1 : dq_x;
  assign qmy  = dovf_y ? '1 : dq_y;
  assign qsx  = dside.x_neg ? -$signed(TW'(qmx)) : $signed(TW'(qmx));
  assign qsy  = dside.y_neg ? -$signed(TW'(qmy)) : $signed(TW'(qmy));
  assign cenx = $signed(TW'(hw_r) << COORD_FRAC_BITS);
  assign ceny = $signed(TW'(hh_r) << COORD_FRAC_BITS);

  assign tx9 = tx8_r[TW-1] ? tx8_r + $signed(FMASK) : tx8_r;
  assign ty9 = ty8_r[TW-1] ? ty8_r + $signed(FMASK) : ty8_r;
  assign shx = tx9 >>> COORD_FRAC_BITS;
  assign shy = ty9 >>> COORD_FRAC_BITS;
  assign pxs = sat_pix(shx);
  assign pys = sat_pix(shy);

endmodule

// ===== rtl/vrp_divpipe.sv =====
// Pipelined restoring divider for two dividends that share one divisor.
// One quotient bit per stage; uses vrp_pkg for widths and the sideband type.

module vrp_divpipe #(
  parameter int QBITS = 34
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic [vrp_pkg::NUM_W-1:0] num_x,
  input  logic [vrp_pkg::NUM_W-1:0] num_y,
  input  logic [vrp_pkg::SD_W-1:0]  den,
  input  vrp_pkg::vrp_side_t        side_in,
  output logic                     out_valid,
  output logic [QBITS-1:0]         quo_x,
  output logic [QBITS-1:0]         quo_y,
  output logic                     ovf_x,
  output logic                     ovf_y,
  output vrp_pkg::vrp_side_t        side_out
);

  localparam int NW = vrp_pkg::NUM_W;
  localparam int DW = vrp_pkg::SD_W;
  localparam int HI_W = NW - QBITS;

  logic                vld_r  [0:QBITS];
  logic [DW-1:0]       remx_r [0:QBITS];
  logic [DW-1:0]       remy_r [0:QBITS];
  logic [QBITS-1:0]    lox_r  [0:QBITS];
  logic [QBITS-1:0]    loy_r  [0:QBITS];
  logic [QBITS-1:0]    qx_r   [0:QBITS];
  logic [QBITS-1:0]    qy_r   [0:QBITS];
  logic                ovfx_r [0:QBITS];
  logic                ovfy_r [0:QBITS];
  logic [DW-1:0]       den_r  [0:QBITS];
  vrp_pkg::vrp_side_t  side_r [0:QBITS];

  logic [DW:0]   stepx [0:QBITS-1];
  logic [DW:0]   stepy [0:QBITS-1];
  logic [HI_W-1:0] hix;
  logic [HI_W-1:0] hiy;
  logic          ovfx_in;
  logic          ovfy_in;

  function automatic logic [DW:0] div_step(input logic [DW-1:0] rem, input logic nb,
                                           input logic [DW-1:0] d);
    logic [DW:0] trial;
    logic        ge;
    trial = {rem, nb};
    ge = (trial >= {1'b0, d});
    div_step = {ge, ge ? DW'(trial - {1'b0, d}) : trial[DW-1:0]};
  endfunction

  assign hix = num_x[NW-1:QBITS];
  assign hiy = num_y[NW-1:QBITS];
  assign ovfx_in = (64'(hix) >= 64'(den));
  assign ovfy_in = (64'(hiy) >= 64'(den));

  always_comb begin
    for (int k = 0; k < QBITS; k++) begin
      stepx[k] = div_step(remx_r[k], lox_r[k][QBITS-1], den_r[k]);
      stepy[k] = div_step(remy_r[k], loy_r[k][QBITS-1], den_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= QBITS; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else begin
      vld_r[0] <= in_valid;
      for (int k = 0; k < QBITS; k++) begin
        vld_r[k+1] <= vld_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    remx_r[0] <= ovfx_in ? '0 : DW'(hix);
    remy_r[0] <= ovfy_in ? '0 : DW'(hiy);
    lox_r[0]  <= num_x[QBITS-1:0];
    loy_r[0]  <= num_y[QBITS-1:0];
    qx_r[0]   <= '0;
    qy_r[0]   <= '0;
    ovfx_r[0] <= ovfx_in;
    ovfy_r[0] <= ovfy_in;
    den_r[0]  <= den;
    side_r[0] <= side_in;
    for (int k = 0; k < QBITS; k++) begin
      remx_r[k+1] <= stepx[k][DW-1:0];
      remy_r[k+1] <= stepy[k][DW-1:0];
      lox_r[k+1]  <= lox_r[k] << 1;
      loy_r[k+1]  <= loy_r[k] << 1;
      qx_r[k+1]   <= {qx_r[k][QBITS-2:0], stepx[k][DW]};
      qy_r[k+1]   <= {qy_r[k][QBITS-2:0], stepy[k][DW]};
      ovfx_r[k+1] <= ovfx_r[k];
      ovfy_r[k+1] <= ovfy_r[k];
      den_r[k+1]  <= den_r[k];
      side_r[k+1] <= side_r[k];
    end
  end

  assign out_valid = vld_r[QBITS];
  assign quo_x     = qx_r[QBITS];
  assign quo_y     = qy_r[QBITS];
  assign ovf_x     = ovfx_r[QBITS];
  assign ovf_y     = ovfy_r[QBITS];
  assign side_out  = side_r[QBITS];

endmodule

// ===== test/tb_vertex_rotate_project.sv =====
// Self-checking testbench for vertex_rotate_project: directed and random vertices
// under several register settings, each point checked against a local predictor.
// Depends on vrp_pkg and the vertex_rotate_project RTL.

module tb_vertex_rotate_project;
  timeunit 1ns;
  timeprecision 1ps;

  import vrp_pkg::*;

  localparam int     CF_BITS     = 16;
  localparam int     TF_BITS     = 14;
  localparam int     CYCLE_LIMIT = 200000;
  localparam int     DRAIN_WAIT  = CF_BITS + 45;
  localparam longint PIX_SCALE   = longint'(1) << CF_BITS;
  localparam longint S32_MAX     = 64'sd2147483647;
  localparam longint S32_MIN     = -64'sd2147483648;
  localparam logic [31:0] ONE    = 32'h0001_0000;
  localparam logic [31:0] MAXV   = 32'h7FFF_FFFF;
  localparam logic [31:0] MINV   = 32'h8000_0000;
  localparam logic [15:0] UNIT_COS [6] = '{16'd16384, 16'd15137, 16'd11585,
                                           16'd6270, 16'd0, 16'd14189};
  localparam logic [15:0] UNIT_SIN [6] = '{16'd0, 16'd6270, 16'd11585,
                                           16'd15137, 16'd16384, 16'd8192};

  typedef struct {
    logic signed [CRD_W-1:0] vx;
    logic signed [CRD_W-1:0] vy;
    logic signed [CRD_W-1:0] vz;
  } vertex_t;

  typedef struct {
    logic signed [PIX_W-1:0] px;
    logic signed [PIX_W-1:0] py;
    logic                    clipped;
  } screen_point_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic signed [CRD_W-1:0] in_vx = '0;
  logic signed [CRD_W-1:0] in_vy = '0;
  logic signed [CRD_W-1:0] in_vz = '0;
  logic                    out_valid;
  logic signed [PIX_W-1:0] out_px;
  logic signed [PIX_W-1:0] out_py;
  logic                    out_clipped;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [ADDR_W-1:0]       paddr = '0;
  logic [DATA_W-1:0]       pwdata = '0;
  logic [DATA_W-1:0]       prdata;
  logic                    pready;

  logic [31:0]             yaw_cs = YAW_RST;
  logic [31:0]             pitch_cs = PITCH_RST;
  logic signed [31:0]      cam_x = '0;
  logic signed [31:0]      cam_y = '0;
  logic signed [31:0]      cam_z = '0;
  logic [SD_W-1:0]         scr_dist = SDIST_RST;
  logic [CTR_W-1:0]        half_w = HALFW_RST;
  logic [CTR_W-1:0]        half_h = HALFH_RST;

  vertex_t                 pending_vertices[$];
  screen_point_t           expected_points[$];
  vertex_t                 cur_vertex;
  int                      gap_left = 0;
  bit                      allow_idle = 1'b1;
  int                      mismatch_count = 0;
  int                      cycle_count = 0;

  vertex_rotate_project #(
    .COORD_FRAC_BITS(CF_BITS),
    .TRIG_FRAC_BITS (TF_BITS)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_vx      (in_vx),
    .in_vy      (in_vy),
    .in_vz      (in_vz),
    .out_valid  (out_valid),
    .out_px     (out_px),
    .out_py     (out_py),
    .out_clipped(out_clipped),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint clamp(longint v, longint lo, longint hi, inout bit clip);
    if (v > hi) begin
      clip = 1'b1;
      return hi;
    end
    if (v < lo) begin
      clip = 1'b1;
      return lo;
    end
    return v;
  endfunction

  // Exact a*c - b*s, rounded half up to the coordinate format, then saturated.
  function automatic longint rotate_term(longint a, longint c, longint b, longint s,
                                         inout bit clip);
    longint sum;
    sum = a * c - b * s + (longint'(1) << (TF_BITS - 1));
    return clamp(sum >>> TF_BITS, S32_MIN, S32_MAX, clip);
  endfunction

  function automatic longint to_pixel(longint coord, longint depth, logic [CTR_W-1:0] centre,
                                      inout bit clip);
    longint q;
    longint total;
    q = (coord * longint'(scr_dist)) / depth;
    total = longint'(centre) * PIX_SCALE + q;
    return clamp(total / PIX_SCALE, -64'sd32768, 64'sd32767, clip);
  endfunction

  function automatic screen_point_t project_vertex(vertex_t v);
    longint x, y, z, yc, ys, pc, ps, x1, z1, y2, z2, px, py;
    bit clip;
    screen_point_t p;
    x = v.vx;
    y = v.vy;
    z = v.vz;
    yc = $signed(yaw_cs[15:0]);
    ys = $signed(yaw_cs[31:16]);
    pc = $signed(pitch_cs[15:0]);
    ps = $signed(pitch_cs[31:16]);
    clip = 1'b0;
    x1 = rotate_term(x, yc, z, ys, clip);
    z1 = rotate_term(z, yc, -x, ys, clip);
    y2 = rotate_term(y, pc, z1, ps, clip);
    z2 = rotate_term(z1, pc, -y, ps, clip);
    x1 = clamp(x1 + cam_x, S32_MIN, S32_MAX, clip);
    y2 = clamp(y2 + cam_y, S32_MIN, S32_MAX, clip);
    z2 = clamp(z2 + cam_z, S32_MIN, S32_MAX, clip);
    if (z2 <= 0) begin
      clip = 1'b1;
      px = (x1 >= 0) ? 32767 : -32768;
      py = (y2 >= 0) ? 32767 : -32768;
    end else begin
      px = to_pixel(x1, z2, half_w, clip);
      py = to_pixel(y2, z2, half_h, clip);
    end
    p.px = px[PIX_W-1:0];
    p.py = py[PIX_W-1:0];
    p.clipped = clip;
    return p;
  endfunction

  task automatic report_mismatch(string what);
    mismatch_count++;
    $display("[%0t] ERROR: %s", $time, what);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Request driver: holds start until accepted, with random idle bursts between requests.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap_left <= 0;
    end else begin
      if (start && !busy) begin
        expected_points.push_back(project_vertex(cur_vertex));
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start <= 1'b0;
        end else if (pending_vertices.size() > 0) begin
          if (allow_idle && $urandom_range(0, 9) == 0) begin
            gap_left <= $urandom_range(0, 16);
            start <= 1'b0;
          end else begin
            cur_vertex = pending_vertices.pop_front();
            in_vx <= cur_vertex.vx;
            in_vy <= cur_vertex.vy;
            in_vz <= cur_vertex.vz;
            start <= 1'b1;
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    screen_point_t e;
    if (rst_n && out_valid) begin
      if (expected_points.size() == 0) begin
        report_mismatch($sformatf("unexpected point px=%0d py=%0d clipped=%0b",
                                  out_px, out_py, out_clipped));
      end else begin
        e = expected_points.pop_front();
        if (out_px !== e.px)
          report_mismatch($sformatf("px got %0d, want %0d", out_px, e.px));
        if (out_py !== e.py)
          report_mismatch($sformatf("py got %0d, want %0d", out_py, e.py));
        if (out_clipped !== e.clipped)
          report_mismatch($sformatf("clipped got %0b, want %0b", out_clipped, e.clipped));
      end
    end
  end

  task automatic write_register(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_YAW:   yaw_cs = val;
      REG_PITCH: pitch_cs = val;
      REG_CAMX:  cam_x = val;
      REG_CAMY:  cam_y = val;
      REG_CAMZ:  cam_z = val;
      REG_SDIST: scr_dist = val[SD_W-1:0];
      REG_HALFW: half_w = val[CTR_W-1:0];
      REG_HALFH: half_h = val[CTR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_registers(logic [31:0] yaw, logic [31:0] pitch, logic [31:0] cx,
                               logic [31:0] cy, logic [31:0] cz, logic [31:0] sd,
                               logic [31:0] hw, logic [31:0] hh);
    write_register(REG_YAW, yaw);
    write_register(REG_PITCH, pitch);
    write_register(REG_CAMX, cx);
    write_register(REG_CAMY, cy);
    write_register(REG_CAMZ, cz);
    write_register(REG_SDIST, sd);
    write_register(REG_HALFW, hw);
    write_register(REG_HALFH, hh);
  endtask

  task automatic wait_all_done();
    @(negedge clk);
    while (pending_vertices.size() != 0 || start || expected_points.size() != 0)
      @(negedge clk);
  endtask

  task automatic push_vertex(logic [31:0] vx, logic [31:0] vy, logic [31:0] vz);
    vertex_t v;
    v.vx = vx;
    v.vy = vy;
    v.vz = vz;
    pending_vertices.push_back(v);
  endtask

  function automatic logic [31:0] pick_extreme();
    case ($urandom_range(0, 4))
      0: return MAXV;
      1: return MINV;
      2: return '0;
      3: return '1;
      default: return 32'd1;
    endcase
  endfunction

  function automatic logic [31:0] pick_angle(int wild);
    logic [15:0] c, s;
    int k;
    if ($urandom_range(1, 100) <= wild) begin
      case ($urandom_range(0, 3))
        0: return 32'h7FFF_7FFF;
        1: return 32'h8000_8000;
        default: return $urandom;
      endcase
    end
    k = $urandom_range(0, 5);
    c = UNIT_COS[k];
    s = UNIT_SIN[k];
    if ($urandom_range(0, 1)) c = -c;
    if ($urandom_range(0, 1)) s = -s;
    return {s, c};
  endfunction

  function automatic logic [31:0] pick_value(int wild, logic [31:0] lo, logic [31:0] hi);
    if ($urandom_range(1, 100) <= wild)
      return $urandom_range(0, 1) ? pick_extreme() : $urandom;
    return $urandom_range(lo, hi);
  endfunction

  task automatic pick_settings(int wild);
    set_registers(pick_angle(wild), pick_angle(wild),
                  pick_value(wild, 0, 32'h40_0000) - 32'h20_0000,
                  pick_value(wild, 0, 32'h40_0000) - 32'h20_0000,
                  pick_value(wild, 32'h10_0000, 32'h80_0000),
                  pick_value(wild, 32'h40_0000, 32'h400_0000),
                  pick_value(wild, 0, 4095), pick_value(wild, 0, 4095));
  endtask

  function automatic logic [31:0] pick_coord(int mode);
    if (mode < 70) return $urandom_range(0, 32'h80_0000) - 32'h40_0000;
    if (mode < 85) return $urandom;
    if (mode < 93) return $signed($urandom) >>> $urandom_range(0, 31);
    return pick_extreme();
  endfunction

  task automatic queue_random_vertices(int count);
    int mode;
    repeat (count) begin
      mode = $urandom_range(0, 99);
      push_vertex(pick_coord(mode), pick_coord(mode), pick_coord(mode));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: identity rotation, unit screen distance, 320 by 240 centre.
    push_vertex(0, 0, ONE);
    push_vertex(ONE, -ONE, ONE);
    push_vertex(32'h0002_8000, 32'h0000_8000, 32'h0002_0000);
    push_vertex(-32'h0003_0000, 32'h0007_0000, 32'h0000_8000);
    push_vertex(32'h0000_8000, -32'h0000_8000, ONE);
    push_vertex(ONE, -ONE, 0);
    push_vertex(-ONE, ONE, -ONE);
    push_vertex(0, 0, '1);
    push_vertex(MAXV, MINV, 32'd1);
    push_vertex(MAXV, MAXV, MAXV);
    push_vertex(MINV, MINV, MINV);
    push_vertex('1, '1, '1);
    wait_all_done();

    // Extreme trig, camera and screen values: rotation and camera saturation.
    set_registers(32'h7FFF_7FFF, 32'h8000_8000, MAXV, MINV, MAXV, MAXV, 4095, 0);
    push_vertex(MAXV, MAXV, MAXV);
    push_vertex(MINV, MINV, MINV);
    push_vertex(0, 0, 0);
    push_vertex(ONE, ONE, ONE);
    push_vertex(MINV, MAXV, 0);
    wait_all_done();

    // Everything zero: depth is never positive.
    set_registers(0, 0, 0, 0, 0, 0, 0, 0);
    push_vertex(32'd1, 32'd2, 32'd3);
    push_vertex(-32'd1, -32'd2, -32'd3);
    push_vertex(MAXV, MINV, 0);
    wait_all_done();

    for (int phase = 0; phase < 9; phase++) begin
      pick_settings(phase < 3 ? 0 : 30);
      allow_idle = (phase < 8) && ($urandom_range(0, 3) != 0);
      queue_random_vertices(105);
      wait_all_done();
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
